@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types for the shell command tokenizer: result kinds, one result
// entry, and the bundle of up to three results that one input byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    K_BYTE = 3'd0,
    K_TEND = 3'd1,
    K_LEND = 3'd2,
    K_IEND = 3'd3,
    K_LOST = 3'd4
  } kind_t;

  // Most results one input can cause
  localparam int MAX_RES = 3;

  // Default depth of the result queue
  localparam int RESQ_DEPTH = 4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } sct_res_t;

  typedef struct packed {
    sct_res_t [MAX_RES-1:0] ent;
    logic [1:0]             cnt;
  } sct_bundle_t;

endpackage

`default_nettype wire

@@ rtl/shell_command_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// shell_command_tokenizer_top
// Tokenizes a command-line byte stream into token bytes, token ends, line
// ends, input end and lost-quote errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one byte_req per transaction,
//   or an end_of_input mark. Output channel (out_valid/out_ready) carries one
//   result per transaction: kind, char_out, and last on the final result that
//   a given input caused. An input may cause zero to three results.
//   The results of an accepted input are registered into the result queue,
//   behind any results still queued. One input is accepted per cycle as long
//   as the result queue has room for three more results; the output side
//   drains one result per cycle while out_ready is high.
//   The result queue (RESQ_DEPTH entries) lets input keep flowing while the
//   receiver stalls; once it holds more than RESQ_DEPTH-3 results, in_ready
//   drops until results are taken.
//   Reset (rst, synchronous) empties the queue and returns the lexer to the
//   between-tokens mode with no pending separator or open quote.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_command_tokenizer_top #(
  parameter int RESQ_DEPTH = sct_pkg::RESQ_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_req,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      kind,
  output logic [7:0]      char_out,
  output logic            last
);
  import sct_pkg::*;

  sct_bundle_t bundle;
  sct_res_t    head;
  logic        in_fire;
  logic        space;

  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  // Lexer mode machine
  sct_step u_step (
    .clk          (clk),
    .rst          (rst),
    .take         (in_fire),
    .byte_req     (byte_req),
    .end_of_input (end_of_input),
    .bundle       (bundle)
  );

  // Result queue
  sct_resq #(
    .Depth (RESQ_DEPTH)
  ) u_resq (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire),
    .push_data  (bundle),
    .space      (space),
    .head_valid (out_valid),
    .head       (head),
    .pop        (out_valid && out_ready)
  );

  assign kind     = head.kind;
  assign char_out = head.ch;
  assign last     = head.last;

endmodule

`default_nettype wire

@@ rtl/sct_step.sv @@
// ----------------------------------------------------------------------------
// sct_step
// Lexer mode machine: holds the mode, the pending separator and the open
// quote, and turns one input byte into a bundle of zero to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        byte_req,
  input  wire logic              end_of_input,
  output sct_pkg::sct_bundle_t   bundle
);
  import sct_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_WORD    = 3'd1,
    M_QUOTE   = 3'd2,
    M_ESC     = 3'd3,
    M_PEND    = 3'd4,
    M_COMMENT = 3'd5
  } mode_t;

  localparam logic [7:0] C_SP   = 8'h20;
  localparam logic [7:0] C_TAB  = 8'h09;
  localparam logic [7:0] C_LF   = 8'h0A;
  localparam logic [7:0] C_HASH = 8'h23;
  localparam logic [7:0] C_SQ   = 8'h27;
  localparam logic [7:0] C_DQ   = 8'h22;
  localparam logic [7:0] C_SEMI = 8'h3B;
  localparam logic [7:0] C_LT   = 8'h3C;
  localparam logic [7:0] C_LP   = 8'h28;
  localparam logic [7:0] C_RP   = 8'h29;
  localparam logic [7:0] C_BAR  = 8'h7C;
  localparam logic [7:0] C_AMP  = 8'h26;
  localparam logic [7:0] C_GT   = 8'h3E;
  localparam logic [7:0] C_BSL  = 8'h5C;

  mode_t      mode, mode_next;
  logic [7:0] pending_sep, pending_sep_next;
  logic [7:0] quote_char, quote_char_next;

  logic       do_idle;
  logic       do_quote;
  logic [1:0] n;
  logic       word_char;

  // Flag bytes that may continue a word
  always_comb begin
    unique case (byte_req) inside
      C_SEMI, C_LT, C_LP, C_RP, C_BAR, C_AMP, C_GT,
      C_SQ, C_DQ, C_SP, C_TAB, C_HASH, C_LF: word_char = 1'b0;
      default:                                word_char = 1'b1;
    endcase
  end

  // Decode one byte into results and next state
  always_comb begin
    bundle           = '0;
    n                = 2'd0;
    mode_next        = mode;
    pending_sep_next = pending_sep;
    quote_char_next  = quote_char;
    do_idle          = 1'b0;
    do_quote         = 1'b0;

    unique case (mode)
      M_WORD: begin
        if (!end_of_input && word_char) begin
          bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
          n = n + 2'd1;
        end else begin
          bundle.ent[n] = '{kind: K_TEND, ch: 8'd0, last: 1'b0};
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_QUOTE: begin
        do_quote = 1'b1;
      end
      M_ESC: begin
        if (!end_of_input && (byte_req == C_DQ || byte_req == C_BSL)) begin
          bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
          n = n + 2'd1;
          mode_next = M_QUOTE;
        end else begin
          bundle.ent[n] = '{kind: K_BYTE, ch: C_BSL, last: 1'b0};
          n = n + 2'd1;
          do_quote = 1'b1;
        end
      end
      M_PEND: begin
        pending_sep_next = 8'd0;
        if (!end_of_input && byte_req == pending_sep) begin
          bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
          n = n + 2'd1;
          bundle.ent[n] = '{kind: K_TEND, ch: 8'd0, last: 1'b0};
          n = n + 2'd1;
          mode_next = M_IDLE;
        end else begin
          bundle.ent[n] = '{kind: K_TEND, ch: 8'd0, last: 1'b0};
          n = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (end_of_input) begin
          bundle.ent[n] = '{kind: K_IEND, ch: 8'd0, last: 1'b0};
          n = n + 2'd1;
          mode_next = M_IDLE;
        end else if (byte_req == C_LF) begin
          mode_next = M_IDLE;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Handle the byte as between tokens
    if (do_idle) begin
      mode_next = M_IDLE;
      if (end_of_input) begin
        bundle.ent[n] = '{kind: K_IEND, ch: 8'd0, last: 1'b0};
        n = n + 2'd1;
      end else begin
        unique case (byte_req) inside
          C_SP, C_TAB: begin
          end
          C_LF: begin
            bundle.ent[n] = '{kind: K_LEND, ch: 8'd0, last: 1'b0};
            n = n + 2'd1;
          end
          C_HASH: begin
            bundle.ent[n] = '{kind: K_LEND, ch: 8'd0, last: 1'b0};
            n = n + 2'd1;
            mode_next = M_COMMENT;
          end
          C_SQ, C_DQ: begin
            quote_char_next = byte_req;
            mode_next = M_QUOTE;
          end
          C_SEMI, C_LT, C_LP, C_RP: begin
            bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
            n = n + 2'd1;
            bundle.ent[n] = '{kind: K_TEND, ch: 8'd0, last: 1'b0};
            n = n + 2'd1;
          end
          C_BAR, C_AMP, C_GT: begin
            bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
            n = n + 2'd1;
            pending_sep_next = byte_req;
            mode_next = M_PEND;
          end
          default: begin
            bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
            n = n + 2'd1;
            mode_next = M_WORD;
          end
        endcase
      end
    end

    // Handle the byte inside quotes
    if (do_quote) begin
      mode_next = M_QUOTE;
      if (end_of_input) begin
        bundle.ent[n] = '{kind: K_TEND, ch: 8'd0, last: 1'b0};
        n = n + 2'd1;
        bundle.ent[n] = '{kind: K_LOST, ch: 8'd0, last: 1'b0};
        n = n + 2'd1;
        quote_char_next = 8'd0;
        mode_next = M_IDLE;
      end else if (byte_req == quote_char) begin
        bundle.ent[n] = '{kind: K_TEND, ch: 8'd0, last: 1'b0};
        n = n + 2'd1;
        quote_char_next = 8'd0;
        mode_next = M_IDLE;
      end else if (byte_req == C_BSL && quote_char == C_DQ) begin
        mode_next = M_ESC;
      end else begin
        bundle.ent[n] = '{kind: K_BYTE, ch: byte_req, last: 1'b0};
        n = n + 2'd1;
      end
    end

    // Mark the final result of this transaction
    if (n != 2'd0) begin
      bundle.ent[n - 2'd1].last = 1'b1;
    end
    bundle.cnt = n;
  end

  // Hold lexer state, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      pending_sep <= 8'd0;
      quote_char  <= 8'd0;
    end else if (take) begin
      mode        <= mode_next;
      pending_sep <= pending_sep_next;
      quote_char  <= quote_char_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sct_resq.sv @@
// ----------------------------------------------------------------------------
// sct_resq
// Result queue: takes a whole bundle of up to three results in one push and
// hands them out one per cycle, while the receiver is ready, on a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_resq #(
  parameter int Depth = sct_pkg::RESQ_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire sct_pkg::sct_bundle_t push_data,
  output logic                      space,
  output logic                      head_valid,
  output sct_pkg::sct_res_t         head,
  input  wire logic                 pop
);
  import sct_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  sct_res_t            mem [Depth];
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW-1:0]     wr_ptr;
  logic [CntW-1:0]     count;
  logic [1:0]          push_cnt;

  // Advance a pointer by k places around the ring
  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] p,
                                               input logic [1:0] k);
    logic [PtrW+1:0] s;
    s = (PtrW + 2)'(p) + (PtrW + 2)'(k);
    if (s >= (PtrW + 2)'(Depth)) begin
      s = s - (PtrW + 2)'(Depth);
    end
    return s[PtrW-1:0];
  endfunction

  assign push_cnt   = push ? push_data.cnt : 2'd0;
  assign space      = count <= CntW'(Depth - MAX_RES);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  // Write the bundle entries into consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_cnt) begin
        mem[wrap_add(wr_ptr, 2'(i))] <= push_data.ent[i];
      end
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wrap_add(wr_ptr, push_cnt);
      rd_ptr <= wrap_add(rd_ptr, {1'b0, pop});
      count  <= count + CntW'(push_cnt) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/sct_checker.sv @@
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks for the shell command tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] kind,
  input wire logic [7:0] char_out,
  input wire logic       last
);
  import sct_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_out)
      && $stable(last))
    else $error("stalled result changed");

  // Only token bytes carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_BYTE |-> char_out == 8'd0)
    else $error("non-byte result carries a character");

  // Input backpressure only comes from queued results
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // Reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind shell_command_tokenizer_top sct_checker u_sct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .char_out  (char_out),
  .last      (last)
);

`default_nettype wire
